FILE: rtl/greedy_deadline_job_scheduler_unit_defines.svh
// Assertion macros shared by the checker files.
`ifndef GREEDY_DEADLINE_JOB_SCHEDULER_UNIT_DEFINES_SVH
`define GREEDY_DEADLINE_JOB_SCHEDULER_UNIT_DEFINES_SVH

// Checks an implication on every clock edge outside reset.
`define GDJS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition holds in every cycle outside reset.
`define GDJS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    `GDJS_ASSERT(lbl, clk, rst_n, (1'b1 |-> (cond)), msg)

`endif

FILE: rtl/gdjs_pkg.sv
package gdjs_pkg;

    localparam int MAX_JOBS   = 64;
    localparam int MAX_SLOTS  = 32;

    localparam int JOB_IDX_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int JOB_CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int SLOT_IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SLOT_CNT_W = $clog2(MAX_SLOTS + 1);

    localparam int ID_W       = 16;
    localparam int DL_W       = 8;
    localparam int PROFIT_W   = 16;
    localparam int CFG_W      = 6;
    localparam int IDXOUT_W   = 5;
    localparam int SUM_W      = 22;

    localparam int JOB_W      = ID_W + DL_W + PROFIT_W;
    localparam int IN_DATA_W  = ((JOB_W + 7) / 8) * 8;
    localparam int OUT_FLD_W  = IDXOUT_W + ID_W + SUM_W + 1;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_SLOT_COUNT = 1'b0;
    localparam logic [CFG_W-1:0] SLOT_COUNT_RST = CFG_W'(32);

    typedef struct packed {
        logic [PROFIT_W-1:0] profit;
        logic [DL_W-1:0]     deadline;
        logic [ID_W-1:0]     id;
    } t_job;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_SCAN_END,
        ST_PLACE_INIT,
        ST_PLACE,
        ST_OUT
    } t_state;

endpackage

FILE: rtl/gdjs_ram.sv
module gdjs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/greedy_deadline_job_scheduler_unit.sv
// Channel   Direction  Payload
// s (jobs)  in         tdata: job_id, deadline, profit; tlast: last_job
// m (slots) out        tdata: slot_index, slot_job, total_profit, jobs_dropped;
//                      tuser: slot_filled; tlast: last_slot
// apb       in/out     register 0 at byte address 0: slot_count
//
// Job items are taken one per cycle while loading. The item with tlast starts
// scheduling: each round scans the N stored jobs through the job memory read port
// for the most profitable untaken job, then searches backward from its deadline.
// The slot results then leave at one item per cycle while the output is taken.
// Reset is synchronous; it empties the set and sets slot_count to 32.
// The input is ready only while loading; the last slot item may still be waiting.
module greedy_deadline_job_scheduler_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // job_id[15:0], deadline[23:16], profit[39:24]
    input  logic [gdjs_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // slot_index[4:0], slot_job[20:5], total_profit[42:21], jobs_dropped[43]
    output logic [gdjs_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // slot_filled[0]
    output logic                            o_m_tuser,
    output logic                            o_m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gdjs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gdjs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gdjs_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int JW  = gdjs_pkg::JOB_IDX_W;
    localparam int JCW = gdjs_pkg::JOB_CNT_W;
    localparam int SW  = gdjs_pkg::SLOT_IDX_W;
    localparam int SCW = gdjs_pkg::SLOT_CNT_W;

    gdjs_pkg::t_state r_state, n_state;

    logic [gdjs_pkg::CFG_W-1:0]        r_slot_count;
    logic [JCW-1:0]                    r_count;
    logic                              r_overflow;
    logic [gdjs_pkg::MAX_JOBS-1:0]     r_taken;
    logic [gdjs_pkg::MAX_SLOTS-1:0]    r_slot_valid;
    logic [gdjs_pkg::ID_W-1:0]         r_slot_id [gdjs_pkg::MAX_SLOTS];
    logic [gdjs_pkg::SUM_W-1:0]        r_sum;

    logic [JCW-1:0]                    r_round;
    logic [JCW-1:0]                    r_k;
    logic [JW-1:0]                     r_kd;
    logic                              r_kd_vld;
    logic                              r_found;
    gdjs_pkg::t_job                    r_best;
    logic [JW-1:0]                     r_best_k;
    logic [SCW-1:0]                    r_d;
    logic [SCW-1:0]                    r_s;

    logic                              r_ovld;
    logic [gdjs_pkg::OUT_DATA_W-1:0]   r_odata;
    logic                              r_ouser;
    logic                              r_olast;

    logic                              in_acc;
    logic                              store_full;
    logic                              ram_we;
    logic [gdjs_pkg::JOB_W-1:0]        ram_q;
    gdjs_pkg::t_job                    q_job;
    gdjs_pkg::t_job                    in_job;
    logic [SCW-1:0]                    nslots;
    logic [gdjs_pkg::DL_W-1:0]         dl_clamp;
    logic [SCW-1:0]                    d_m1;
    logic [SW-1:0]                     slot_rd_idx;
    logic                              slot_rd_valid;
    logic [gdjs_pkg::ID_W-1:0]         slot_rd_id;
    logic                              out_load;
    logic                              out_is_last;
    logic                              round_done;
    logic                              cfg_we;

    // Effective slot count: zero counts as one, large values saturate.
    always_comb begin
        if (r_slot_count == '0) begin
            nslots = SCW'(1);
        end else if ((SCW + 1)'(r_slot_count) > (SCW + 1)'(gdjs_pkg::MAX_SLOTS)) begin
            nslots = SCW'(gdjs_pkg::MAX_SLOTS);
        end else begin
            nslots = SCW'(r_slot_count);
        end
    end

    assign in_job     = gdjs_pkg::t_job'(i_s_tdata[gdjs_pkg::JOB_W-1:0]);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign store_full = (r_count == JCW'(gdjs_pkg::MAX_JOBS));
    assign ram_we     = in_acc && !store_full;
    assign q_job      = gdjs_pkg::t_job'(ram_q);

    assign dl_clamp = (r_best.deadline > gdjs_pkg::DL_W'(nslots)) ?
                      gdjs_pkg::DL_W'(nslots) : r_best.deadline;
    assign d_m1     = r_d - SCW'(1);

    // The slot table has one read index, shared by the search and the output.
    assign slot_rd_idx   = (r_state == gdjs_pkg::ST_PLACE) ? d_m1[SW-1:0] : r_s[SW-1:0];
    assign slot_rd_valid = r_slot_valid[slot_rd_idx];
    assign slot_rd_id    = r_slot_id[slot_rd_idx];

    assign round_done  = (r_round + JCW'(1) == r_count);
    assign out_is_last = (r_s + SCW'(1) == nslots);
    assign cfg_we      = psel && penable && pwrite && pready;

    gdjs_ram #(
        .WIDTH (gdjs_pkg::JOB_W),
        .DEPTH (gdjs_pkg::MAX_JOBS)
    ) u_job_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[JW-1:0]),
        .i_wdata (in_job),
        .i_raddr (r_k[JW-1:0]),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            gdjs_pkg::ST_LOAD: begin
                if (in_acc && i_s_tlast) begin
                    n_state = gdjs_pkg::ST_SCAN;
                end
            end
            gdjs_pkg::ST_SCAN: begin
                if (r_k + JCW'(1) == r_count) begin
                    n_state = gdjs_pkg::ST_SCAN_END;
                end
            end
            gdjs_pkg::ST_SCAN_END: begin
                n_state = gdjs_pkg::ST_PLACE_INIT;
            end
            gdjs_pkg::ST_PLACE_INIT: begin
                n_state = gdjs_pkg::ST_PLACE;
            end
            gdjs_pkg::ST_PLACE: begin
                if (r_d == '0 || !slot_rd_valid) begin
                    n_state = round_done ? gdjs_pkg::ST_OUT : gdjs_pkg::ST_SCAN;
                end
            end
            gdjs_pkg::ST_OUT: begin
                if (out_load && out_is_last) begin
                    n_state = gdjs_pkg::ST_LOAD;
                end
            end
            default: n_state = gdjs_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            gdjs_pkg::ST_LOAD: o_s_tready = 1'b1;
            gdjs_pkg::ST_OUT:  out_load   = !r_ovld || i_m_tready;
            default: begin
                o_s_tready = 1'b0;
                out_load   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gdjs_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= gdjs_pkg::SLOT_COUNT_RST;
        end else if (cfg_we && paddr[2:2] == gdjs_pkg::REG_SLOT_COUNT) begin
            r_slot_count <= pwdata[gdjs_pkg::CFG_W-1:0];
        end
    end

    // Set state: loading, scheduling and clearing after the last slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_overflow   <= 1'b0;
            r_taken      <= '0;
            r_slot_valid <= '0;
            r_sum        <= '0;
        end else begin
            if (in_acc) begin
                if (store_full) begin
                    r_overflow <= 1'b1;
                end else begin
                    r_count <= r_count + JCW'(1);
                end
            end
            if (r_state == gdjs_pkg::ST_PLACE_INIT) begin
                r_taken[r_best_k] <= 1'b1;
            end
            if (r_state == gdjs_pkg::ST_PLACE && r_d != '0 && !slot_rd_valid) begin
                r_slot_valid[slot_rd_idx] <= 1'b1;
                r_sum <= r_sum + gdjs_pkg::SUM_W'(r_best.profit);
            end
            if (out_load && out_is_last) begin
                r_count      <= '0;
                r_overflow   <= 1'b0;
                r_taken      <= '0;
                r_slot_valid <= '0;
                r_sum        <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gdjs_pkg::ST_PLACE && r_d != '0 && !slot_rd_valid) begin
            r_slot_id[slot_rd_idx] <= r_best.id;
        end
    end

    // Sequencer counters and the shared profit comparator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kd_vld <= 1'b0;
            r_found  <= 1'b0;
            r_round  <= '0;
            r_k      <= '0;
            r_s      <= '0;
        end else begin
            r_kd_vld <= (r_state == gdjs_pkg::ST_SCAN);
            r_kd     <= r_k[JW-1:0];
            if (r_state == gdjs_pkg::ST_SCAN) begin
                r_k <= r_k + JCW'(1);
            end
            // Read data comes back in the cycle after its address; strict compare keeps the earliest.
            if (r_kd_vld && !r_taken[r_kd] && (!r_found || q_job.profit > r_best.profit)) begin
                r_best   <= q_job;
                r_best_k <= r_kd;
                r_found  <= 1'b1;
            end
            if (r_state == gdjs_pkg::ST_LOAD && in_acc && i_s_tlast) begin
                r_round <= '0;
                r_k     <= '0;
                r_found <= 1'b0;
                r_s     <= '0;
            end
            if (r_state == gdjs_pkg::ST_PLACE_INIT) begin
                r_d <= SCW'(dl_clamp);
            end
            if (r_state == gdjs_pkg::ST_PLACE) begin
                if (r_d == '0 || !slot_rd_valid) begin
                    r_round <= r_round + JCW'(1);
                    r_k     <= '0;
                    r_found <= 1'b0;
                end else begin
                    r_d <= d_m1;
                end
            end
            if (out_load) begin
                r_s <= r_s + SCW'(1);
            end
        end
    end

    // Output register: holds one slot item until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (out_load) begin
            r_ovld <= 1'b1;
        end else if (i_m_tready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_odata <= {(gdjs_pkg::OUT_DATA_W - gdjs_pkg::OUT_FLD_W)'(0),
                        r_overflow,
                        r_sum,
                        slot_rd_valid ? slot_rd_id : gdjs_pkg::ID_W'(0),
                        gdjs_pkg::IDXOUT_W'(r_s)};
            r_ouser <= slot_rd_valid;
            r_olast <= out_is_last;
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;
    assign o_m_tlast  = r_olast;

    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == gdjs_pkg::REG_SLOT_COUNT) ?
                    gdjs_pkg::APB_DATA_W'(r_slot_count) : '0;

endmodule

FILE: rtl/gdjs_checker.sv
`include "greedy_deadline_job_scheduler_unit_defines.svh"

module gdjs_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            i_s_tlast,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [gdjs_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic                            o_m_tuser,
    input logic                            o_m_tlast
);

    // A stalled slot item keeps its contents.
    `GDJS_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast), "slot item changed while stalled")

    // The item that closes a set stops further loading.
    `GDJS_ASSERT(a_last_stops_load, i_clk, i_rst_n, i_s_tvalid && o_s_tready && i_s_tlast |=> !o_s_tready, "input still ready after the last job")

    // An empty slot reports job id zero.
    `GDJS_ASSERT(a_empty_slot_id, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser |-> o_m_tdata[20:5] == 16'd0, "empty slot carries a job id")

    // While slot items other than the last are pending, no new job is taken.
    `GDJS_ASSERT_ALWAYS(a_no_load_mid_output, i_clk, i_rst_n, !(o_m_tvalid && !o_m_tlast && o_s_tready), "input ready during slot output")

endmodule

bind greedy_deadline_job_scheduler_unit gdjs_checker u_gdjs_checker (.*);
